// ----- rtl/core/xtf_pkg.sv -----
`default_nettype none

package xtf_pkg;

	// Character codes used by the filter.
	localparam logic [15:0] CH_TAB  = 16'd9;
	localparam logic [15:0] CH_LF   = 16'd10;
	localparam logic [15:0] CH_CR   = 16'd13;
	localparam logic [15:0] CH_SP   = 16'd32;
	localparam logic [15:0] CH_HASH = 16'd35;
	localparam logic [15:0] CH_AMP  = 16'd38;
	localparam logic [15:0] CH_SEMI = 16'd59;
	localparam logic [15:0] CH_DIG0 = 16'd48;
	localparam logic [15:0] CH_DIG9 = 16'd57;

	localparam int unsigned LEN_W = 15;
	localparam logic [LEN_W-1:0] MAX_STRING_LENGTH = 15'd16384;

	// Entity parser phases.
	typedef enum logic [1:0] {
		PH_TEXT  = 2'd0,
		PH_AMP   = 2'd1,
		PH_DIGIT = 2'd2,
		PH_SPARE = 2'd3
	} xtf_phase_t;

	// Running state carried from one character to the next.
	typedef struct packed {
		xtf_phase_t       phase;
		logic [15:0]      ent_value;
		logic             prev_lf;
		logic             space_run;
		logic             cr_pending;
		logic [LEN_W-1:0] count;
	} xtf_state_t;

	// One result transaction.
	typedef struct packed {
		logic [15:0]      char_out;
		logic             char_valid;
		logic             end_of_string;
		logic [LEN_W-1:0] out_length;
	} xtf_result_t;

	// Everything the step logic derives from one character.
	typedef struct packed {
		xtf_result_t r0;
		xtf_result_t r1;
		logic [1:0]  n_results;
		xtf_state_t  next_state;
	} xtf_step_t;

endpackage

`default_nettype wire

// ----- rtl/core/xtf_step.sv -----
`default_nettype none

module xtf_step (
	input  wire logic [15:0]        code_unit,
	input  wire logic               last_unit,
	input  wire logic               preserve_whitespace,
	input  wire xtf_pkg::xtf_state_t state,
	output xtf_pkg::xtf_step_t      step
);
	import xtf_pkg::*;

	logic [15:0]      ch;
	logic [15:0]      ent_times10;
	logic [15:0]      dig;
	logic [LEN_W-1:0] cnt;
	logic [1:0]       n;
	logic             is_digit;

	// Decimal accumulation: value * 10 as two shifts and an add.
	assign ent_times10 = {state.ent_value[12:0], 3'b000} + {state.ent_value[14:0], 1'b0};
	assign dig         = ch - CH_DIG0;
	assign is_digit    = (ch >= CH_DIG0) && (ch <= CH_DIG9);

	// Whitespace folding when whitespace is collapsed.
	always_comb begin
		ch = code_unit;
		if (!preserve_whitespace && (code_unit == CH_CR || code_unit == CH_LF ||
			code_unit == CH_TAB)) begin
			ch = CH_SP;
		end
	end

	// Work out up to two results and the next state for this character.
	always_comb begin
		xtf_state_t  ns;
		xtf_result_t r0;
		xtf_result_t r1;
		logic        emit_a;
		logic [15:0] char_a;
		logic        emit_b;
		logic [15:0] char_b;
		logic [LEN_W-1:0] cnt_a;

		ns     = state;
		emit_a = 1'b0;
		char_a = CH_LF;
		emit_b = 1'b0;
		char_b = ch;

		// A waiting carriage return turns into a line feed first.
		if (state.cr_pending) begin
			ns.cr_pending = 1'b0;
			if (ch != CH_LF) begin
				emit_a = 1'b1;
			end
		end

		if (ch == CH_CR) begin
			if (!state.prev_lf) begin
				if (last_unit) begin
					emit_b = 1'b1;
					char_b = CH_LF;
				end else begin
					ns.cr_pending = 1'b1;
				end
			end
		end else if (ch == CH_LF) begin
			emit_b = 1'b1;
			char_b = CH_LF;
		end else if (ch == CH_AMP) begin
			ns.phase     = PH_AMP;
			ns.ent_value = '0;
		end else if (state.phase == PH_TEXT) begin
			if (ch == CH_SP) begin
				emit_b       = preserve_whitespace || !state.space_run;
				ns.space_run = 1'b1;
			end else begin
				emit_b       = 1'b1;
				ns.space_run = 1'b0;
			end
		end else begin
			if (state.phase == PH_DIGIT && is_digit) begin
				ns.ent_value = ent_times10 + dig;
			end else if (ch == CH_HASH && state.phase == PH_AMP) begin
				ns.phase = PH_DIGIT;
			end else if (ch == CH_SEMI) begin
				emit_b       = (state.ent_value != 16'd0);
				char_b       = state.ent_value;
				ns.phase     = PH_TEXT;
				ns.space_run = 1'b0;
			end else begin
				ns.phase = PH_TEXT;
			end
		end

		ns.prev_lf = (ch == CH_LF);

		// Saturating length after each emitted character.
		cnt_a = state.count;
		if (emit_a && cnt_a < MAX_STRING_LENGTH) begin
			cnt_a = cnt_a + 1'b1;
		end
		cnt = cnt_a;
		if (emit_b && cnt < MAX_STRING_LENGTH) begin
			cnt = cnt + 1'b1;
		end
		ns.count = cnt;

		// Pack results in emission order.
		r0 = '0;
		r1 = '0;
		n  = 2'd0;
		if (emit_a) begin
			r0 = '{char_out: CH_LF, char_valid: 1'b1, end_of_string: 1'b0, out_length: cnt_a};
			n  = 2'd1;
			if (emit_b) begin
				r1 = '{char_out: char_b, char_valid: 1'b1, end_of_string: last_unit,
					out_length: cnt};
				n  = 2'd2;
			end else begin
				r0.end_of_string = last_unit;
			end
		end else if (emit_b) begin
			r0 = '{char_out: char_b, char_valid: 1'b1, end_of_string: last_unit,
				out_length: cnt};
			n  = 2'd1;
		end else if (last_unit) begin
			// Closing result without a character.
			r0 = '{char_out: 16'd0, char_valid: 1'b0, end_of_string: 1'b1,
				out_length: state.count};
			n  = 2'd1;
		end

		// The string is over: start afresh.
		if (last_unit) begin
			ns = '0;
		end

		step.r0         = r0;
		step.r1         = r1;
		step.n_results  = n;
		step.next_state = ns;
	end

endmodule

`default_nettype wire

// ----- rtl/core/xml_text_whitespace_entity_filter.sv -----
`default_nettype none
// A character is registered in the input stage, its first result in the result register.
// One character per cycle while the result register is free; a character that releases
// a waiting line feed as well as its own result holds the input stage until both are loaded.
// Rate is set by the single result register, which takes one result per cycle when free.
// Reset: arst_n clears the filter state, the stage valid flags and preserve_whitespace.

module xml_text_whitespace_entity_filter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write: preserve_whitespace.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,
	// Input stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] code_unit
	input  wire logic        s_axis_tlast,   // last_unit
	// Result stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [15:0] char_out, [30:16] out_length, [31] zero
	output logic             m_axis_tuser,   // char_valid
	output logic             m_axis_tlast    // end_of_string
);
	import xtf_pkg::*;

	logic        preserve_q;
	logic        valid_s1;
	logic [15:0] code_s1;
	logic        last_s1;
	logic        second_q;
	xtf_state_t  state_q;
	xtf_step_t   step;
	logic        out_valid_q;
	xtf_result_t out_q;
	logic        out_free;
	logic        load_out;
	logic        done_s1;

	// Configuration register, always ready.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preserve_q <= 1'b0;
		end else if (cfg_valid) begin
			preserve_q <= cfg_data;
		end
	end

	// Step logic for the character in the input stage.
	xtf_step u_step (
		.code_unit           (code_s1),
		.last_unit           (last_s1),
		.preserve_whitespace (preserve_q),
		.state               (state_q),
		.step                (step)
	);

	// Handshake control between input stage and result register.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign load_out      = valid_s1 && out_free && (step.n_results != 2'd0);
	assign done_s1       = valid_s1 && out_free && (step.n_results != 2'd2 || second_q);
	assign s_axis_tready = !valid_s1 || done_s1;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			code_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Second-result flag and the running state, committed when the character completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
			state_q  <= '0;
		end else begin
			if (done_s1) begin
				second_q <= 1'b0;
				state_q  <= step.next_state;
			end else if (load_out) begin
				second_q <= 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= second_q ? step.r1 : step.r0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q.out_length, out_q.char_out};
	assign m_axis_tuser  = out_q.char_valid;
	assign m_axis_tlast  = out_q.end_of_string;

`ifndef ASSERT_OFF
	// The second result is only ever pending for a character still held.
	a_second_held: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> valid_s1)
		else $error("second result pending without a held character");

	// After the second result is handed on, the character completes.
	a_second_done: assert property (@(posedge clk) disable iff (!arst_n)
		(second_q && out_free) |=> !second_q)
		else $error("second result flag stuck");

	// A result without a character is only the closing one.
	a_empty_is_close: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.char_valid) |-> out_q.end_of_string)
		else $error("empty result that does not close a string");

	// A finished string leaves no state behind.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done_s1 && last_s1) |=> (state_q == '0))
		else $error("state not cleared after the last character");
`endif

endmodule

`default_nettype wire

// ----- sim/xml_text_whitespace_entity_filter_tb.sv -----
module xml_text_whitespace_entity_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import xtf_pkg::*;

	localparam int          RANDOM_UNITS   = 1250;
	localparam int          LONG_HOLD      = 120;
	localparam int          SETTLE_CYCLES  = 6;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          MAX_REPORTS    = 50;
	localparam logic [15:0] DECIMAL_BASE   = 16'd10;
	localparam logic [15:0] CH_A_LOWER     = 16'd97;
	localparam logic [15:0] CH_A_UPPER     = 16'd65;
	localparam logic [15:0] CH_X_LOWER     = 16'd120;
	localparam logic [15:0] CH_Z_UPPER     = 16'd90;
	localparam logic [15:0] CH_FIVE        = 16'd53;
	localparam logic [15:0] CH_SIX         = 16'd54;

	typedef enum logic {ROW_UNIT, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [15:0] code;
		logic        last;
		bit          typed;
		xtf_result_t result;
	} directed_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [15:0] code_unit
	logic        s_axis_tlast;   // last_unit
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [15:0] char_out, [30:16] out_length, [31] zero
	logic        m_axis_tuser;   // char_valid
	logic        m_axis_tlast;   // end_of_string

	// Predictor state, mirroring the filter's running state and its register.
	logic        keep_ws;
	xtf_phase_t  ent_phase;
	logic [15:0] ent_acc;
	logic        last_was_lf;
	logic        in_space_run;
	logic        cr_waiting;
	logic [14:0] emit_count;

	xtf_result_t   unit_results[$];
	xtf_result_t   filtered_chars_due[$];
	logic [15:0]   draft_units[$];
	directed_row_t directed_rows[$];

	int error_count;
	int units_sent;
	int results_checked;
	int strings_sent;
	int cfg_writes;
	int idle_cycles;
	bit src_steady;
	bit sink_steady;
	bit sink_hold_req;

	xml_text_whitespace_entity_filter uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Clear the running state, as the filter does at the end of each string.
	function automatic void clear_text_state();
		ent_phase    = PH_TEXT;
		ent_acc      = 16'd0;
		last_was_lf  = 1'b0;
		in_space_run = 1'b0;
		cr_waiting   = 1'b0;
		emit_count   = '0;
	endfunction

	// Add one emitted character to the results of the current unit.
	function automatic void emit_char(input logic [15:0] c);
		xtf_result_t res;
		if (emit_count < MAX_STRING_LENGTH) begin
			emit_count++;
		end
		res.char_out      = c;
		res.char_valid    = 1'b1;
		res.end_of_string = 1'b0;
		res.out_length    = emit_count;
		unit_results.push_back(res);
	endfunction

	// Work out the results one accepted unit causes and advance the state.
	function automatic void filter_unit(input logic [15:0] code, input logic last);
		logic [15:0] ch;
		xtf_result_t res;
		unit_results.delete();
		ch = code;
		if (!keep_ws && (ch == CH_CR || ch == CH_LF || ch == CH_TAB)) begin
			ch = CH_SP;
		end
		// A waiting CR becomes a line feed unless this unit is one.
		if (cr_waiting) begin
			cr_waiting = 1'b0;
			if (ch != CH_LF) begin
				emit_char(CH_LF);
			end
		end
		if (ch == CH_CR) begin
			if (!last_was_lf) begin
				if (last) begin
					emit_char(CH_LF);
				end else begin
					cr_waiting = 1'b1;
				end
			end
		end else if (ch == CH_LF) begin
			emit_char(CH_LF);
		end else if (ch == CH_AMP) begin
			ent_phase = PH_AMP;
			ent_acc   = 16'd0;
		end else if (ent_phase == PH_TEXT) begin
			if (ch == CH_SP) begin
				if (keep_ws || !in_space_run) begin
					emit_char(ch);
				end
				in_space_run = 1'b1;
			end else begin
				emit_char(ch);
				in_space_run = 1'b0;
			end
		end else if (ent_phase == PH_DIGIT && ch >= CH_DIG0 && ch <= CH_DIG9) begin
			ent_acc = ent_acc * DECIMAL_BASE + (ch - CH_DIG0);
		end else if (ch == CH_HASH && ent_phase == PH_AMP) begin
			ent_phase = PH_DIGIT;
		end else if (ch == CH_SEMI) begin
			if (ent_acc != 16'd0) begin
				emit_char(ent_acc);
			end
			ent_phase    = PH_TEXT;
			in_space_run = 1'b0;
		end else begin
			ent_phase = PH_TEXT;
		end
		last_was_lf = (ch == CH_LF);
		// The last unit always closes with an end-of-string result.
		if (last) begin
			if (unit_results.size() > 0) begin
				res = unit_results.pop_back();
			end else begin
				res.char_out   = 16'd0;
				res.char_valid = 1'b0;
				res.out_length = emit_count;
			end
			res.end_of_string = 1'b1;
			unit_results.push_back(res);
			clear_text_state();
		end
	endfunction

	// One line per mismatch, up to MAX_REPORTS of them; the count decides the verdict.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (error_count < MAX_REPORTS) begin
			$display("ERROR at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		end
		error_count++;
	endtask

	function automatic int draw_gap(input bit steady);
		if (steady) begin
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	// Offer one unit, entered and left at a falling edge.
	task automatic send_unit(input logic [15:0] code, input logic last, input bit typed,
			input xtf_result_t typed_result);
		int gap;
		gap = draw_gap(src_steady);
		if (gap != 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = code;
		s_axis_tlast  = last;
		do @(posedge clk); while (!s_axis_tready);
		filter_unit(code, last);
		if (typed) begin
			filtered_chars_due.push_back(typed_result);
		end else begin
			foreach (unit_results[i]) filtered_chars_due.push_back(unit_results[i]);
		end
		units_sent++;
		@(negedge clk);
	endtask

	// Stop offering units and let every expected result come out.
	task automatic wait_idle();
		s_axis_tvalid = 1'b0;
		while (filtered_chars_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_keep_ws(input logic value);
		cfg_valid = 1'b1;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		keep_ws = value;
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic void put_row(input row_kind_t kind, input logic [15:0] code,
			input logic last, input bit typed, input logic [15:0] want_char,
			input logic want_valid, input logic want_end, input logic [14:0] want_len);
		directed_row_t row;
		row.kind                 = kind;
		row.code                 = code;
		row.last                 = last;
		row.typed                = typed;
		row.result.char_out      = want_char;
		row.result.char_valid    = want_valid;
		row.result.end_of_string = want_end;
		row.result.out_length    = want_len;
		directed_rows.push_back(row);
	endfunction

	// Append one token of plausible text, mostly well formed, to the draft string.
	function automatic void add_token();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			draft_units.push_back(16'($urandom_range(32, 126)));
		end else if (pick < 55) begin
			case ($urandom_range(0, 3))
				0: draft_units.push_back(CH_SP);
				1: draft_units.push_back(CH_TAB);
				2: draft_units.push_back(CH_CR);
				default: draft_units.push_back(CH_LF);
			endcase
		end else if (pick < 60) begin
			draft_units.push_back(CH_CR);
			draft_units.push_back(CH_LF);
		end else if (pick < 75) begin
			// Numeric entity; long digit runs wrap the value.
			draft_units.push_back(CH_AMP);
			draft_units.push_back(CH_HASH);
			n = $urandom_range(1, 6);
			repeat (n) draft_units.push_back(CH_DIG0 + 16'($urandom_range(0, 9)));
			draft_units.push_back(CH_SEMI);
		end else if (pick < 80) begin
			// Named entity: dropped at its first letter, the rest is plain text.
			draft_units.push_back(CH_AMP);
			n = $urandom_range(1, 3);
			repeat (n) draft_units.push_back(CH_A_LOWER + 16'($urandom_range(0, 25)));
			draft_units.push_back(CH_SEMI);
		end else if (pick < 85) begin
			draft_units.push_back(CH_AMP);
			draft_units.push_back(CH_HASH);
			n = $urandom_range(0, 3);
			repeat (n) draft_units.push_back(CH_DIG0 + 16'($urandom_range(0, 9)));
			draft_units.push_back(CH_A_LOWER + 16'($urandom_range(0, 25)));
		end else if (pick < 90) begin
			draft_units.push_back(CH_AMP);
			draft_units.push_back(CH_SEMI);
		end else begin
			draft_units.push_back(16'($urandom_range(0, 65535)));
		end
	endfunction

	// Result checker: each result transaction against the oldest expectation.
	always @(posedge clk) begin : check_results
		xtf_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (filtered_chars_due.size() == 0) begin
				report_mismatch("result with nothing expected", m_axis_tdata, 32'd0);
			end else begin
				want = filtered_chars_due.pop_front();
				results_checked++;
				if (m_axis_tdata[15:0] !== want.char_out) begin
					report_mismatch("char_out", 32'(m_axis_tdata[15:0]), 32'(want.char_out));
				end
				if (m_axis_tuser !== want.char_valid) begin
					report_mismatch("char_valid", 32'(m_axis_tuser), 32'(want.char_valid));
				end
				if (m_axis_tlast !== want.end_of_string) begin
					report_mismatch("end_of_string", 32'(m_axis_tlast),
						32'(want.end_of_string));
				end
				if (m_axis_tdata[30:16] !== want.out_length) begin
					report_mismatch("out_length", 32'(m_axis_tdata[30:16]),
						32'(want.out_length));
				end
			end
		end
	end

	// Result receiver: waits a drawn number of cycles before each transaction.
	initial begin : result_sink
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0) begin
				sink_steady = !sink_steady;
			end
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				gap = LONG_HOLD;
			end else begin
				gap = draw_gap(sink_steady);
			end
			if (gap != 0) begin
				m_axis_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	// Watchdog: ends the run when no transaction moves for too long.
	initial begin : watchdog
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready) || !arst_n) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// Stimulus.
	initial begin : stimulus
		xtf_result_t no_result;
		int          random_units;
		int          n_tokens;
		bit          hold_done;
		no_result     = '0;
		random_units  = 0;
		hold_done     = 1'b0;
		error_count   = 0;
		units_sent    = 0;
		results_checked = 0;
		strings_sent  = 0;
		cfg_writes    = 0;
		src_steady    = 1'b0;
		sink_steady   = 1'b0;
		sink_hold_req = 1'b0;
		keep_ws       = 1'b0;
		clear_text_state();
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 16'd0;
		s_axis_tlast  = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table; whitespace collapses after reset.
		put_row(ROW_UNIT, CH_A_UPPER, 1'b0, 1'b1, CH_A_UPPER, 1'b1, 1'b0, 15'd1);
		put_row(ROW_UNIT, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b1, 1'b0, 15'd2);
		put_row(ROW_UNIT, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b0, 15'd3);
		put_row(ROW_UNIT, CH_TAB, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_CR, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_LF, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		// A complete numeric entity, then a broken and an empty one.
		put_row(ROW_UNIT, CH_AMP, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_HASH, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_SIX, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_FIVE, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_SEMI, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_AMP, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_X_LOWER, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_AMP, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_SEMI, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_Z_UPPER, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		// Whitespace kept: CR lookahead, CR next to LF, CR inside an entity.
		put_row(ROW_CFG, 16'd1, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_CR, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_X_LOWER, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_CR, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_LF, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_CR, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_AMP, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_CR, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_SEMI, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_CR, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);
		put_row(ROW_UNIT, CH_AMP, 1'b1, 1'b1, 16'd0, 1'b0, 1'b1, 15'd0);
		put_row(ROW_CFG, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 15'd0);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				wait_idle();
				write_keep_ws(directed_rows[i].code[0]);
			end else begin
				send_unit(directed_rows[i].code, directed_rows[i].last, directed_rows[i].typed,
					directed_rows[i].result);
			end
		end
		strings_sent += 3;

		// Random strings built from tokens; the register changes between some of them.
		while (random_units < RANDOM_UNITS) begin
			if ($urandom_range(0, 7) == 0) begin
				wait_idle();
				write_keep_ws(1'($urandom_range(0, 1)));
			end
			src_steady = ($urandom_range(0, 4) == 0);
			if (!hold_done && random_units >= RANDOM_UNITS / 2) begin
				hold_done     = 1'b1;
				sink_hold_req = 1'b1;
				src_steady    = 1'b1;
			end
			draft_units.delete();
			n_tokens = $urandom_range(1, 12);
			repeat (n_tokens) add_token();
			foreach (draft_units[i]) begin
				send_unit(draft_units[i], (i == draft_units.size() - 1), 1'b0, no_result);
			end
			random_units += draft_units.size();
			strings_sent++;
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Filtered %0d units in %0d strings with %0d register writes,",
			units_sent, strings_sent, cfg_writes);
		$display("checked %0d results under random stalls and one long receiver hold; %0d mismatches.",
			results_checked, error_count);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
